[src/sprd_pkg.sv]
// Shared constants and codes for the size-prefixed record deframer.
package sprd_pkg;

   // Default limit on size digits
   localparam int MAX_DIGITS_DEFAULT = 10;

   // Field widths
   localparam int BYTE_W   = 8;
   localparam int LEN_W    = 6;
   localparam int SIZE_W   = 34;
   localparam int FB_W     = 7;
   localparam int FCODE_W  = 3;
   localparam int STATUS_W = 3;
   localparam int CSR_IDX_W = 2;

   // Stream bus widths
   localparam int REQ_TDATA_W = 8;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 16;
   localparam int RSP_TUSER_W = 3;

   // Register reset values
   localparam logic [LEN_W-1:0] CHECKSUM_LEN_RST  = 6'd8;
   localparam logic [LEN_W-1:0] TIMESTAMP_LEN_RST = 6'd19;
   localparam logic [LEN_W-1:0] TYPE_LEN_RST      = 6'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CHECKSUM_LEN  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMESTAMP_LEN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TYPE_LEN      = 2'd2;

   // Characters
   localparam logic [BYTE_W-1:0] BAR_CHAR  = 8'h7C;
   localparam logic [BYTE_W-1:0] ZERO_CHAR = 8'h30;
   localparam logic [BYTE_W-1:0] NINE_CHAR = 8'h39;

   // Saturation point of the field byte counter
   localparam logic [FB_W-1:0] FB_MAX = 7'd127;

   // Parser phases
   localparam logic [1:0] PH_SIZE = 2'd0;
   localparam logic [1:0] PH_BODY = 2'd1;
   localparam logic [1:0] PH_HALT = 2'd2;

   // Field codes
   localparam logic [FCODE_W-1:0] FC_SIZE      = 3'd0;
   localparam logic [FCODE_W-1:0] FC_CHECKSUM  = 3'd1;
   localparam logic [FCODE_W-1:0] FC_TIMESTAMP = 3'd2;
   localparam logic [FCODE_W-1:0] FC_TYPE      = 3'd3;
   localparam logic [FCODE_W-1:0] FC_CONTENT   = 3'd4;
   localparam logic [FCODE_W-1:0] FC_NONE      = 3'd5;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_DIGIT = 3'd1;
   localparam logic [STATUS_W-1:0] ST_TOO_MANY  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_TOO_SMALL = 3'd4;
   localparam logic [STATUS_W-1:0] ST_TRUNCATED = 3'd5;
   localparam logic [STATUS_W-1:0] ST_HALTED    = 3'd6;

endpackage

[src/size_prefixed_record_deframer_unit.sv]
// Size-prefixed record deframer: tags each byte with its field, checks records.
//
//  channel | dir | handshake             | payload
//  req     | in  | req_tvalid/req_tready | tdata: byte_value[7:0]
//          |     |                       | tuser: first_of_file[0], end_of_file[1]
//  rsp     | out | rsp_tvalid/rsp_tready | tdata: byte_out[7:0], record_valid[8],
//          |     |                       |        status[11:9], zero[15:12]
//          |     |                       | tuser: field_code[2:0]; tlast: record_last
//  csr     | in  | csr_we                | csr_index[1:0], csr_wdata[5:0]
//
// One item per cycle while not stalled; results show the cycle after acceptance.
// The parse state and the output register update in the same cycle; the
// longest path is the size multiply-by-ten add or the 34-bit remaining count.
// A held result stalls the input only while rsp_tready is low.
// Reset (synchronous) restores the register defaults and a fresh parser.
module size_prefixed_record_deframer_unit
   import sprd_pkg::*;
#(
   parameter int MAX_DIGITS = MAX_DIGITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   // Input items
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // byte_value[7:0]
   input  logic [REQ_TUSER_W-1:0] req_tuser,  // first_of_file[0], end_of_file[1]
   // Result items
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // byte_out[7:0], record_valid[8],
                                              // status[11:9], zero[15:12]
   output logic [RSP_TUSER_W-1:0] rsp_tuser,  // field_code[2:0]
   output logic                   rsp_tlast,  // record_last
   // Register writes
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [LEN_W-1:0]       csr_wdata
);

   localparam int DC_W = $clog2(MAX_DIGITS + 1);

   // Registers
   logic [LEN_W-1:0]    checksum_len_ff, timestamp_len_ff, type_len_ff;
   logic [1:0]          phase_ff, phase_in;
   logic [DC_W-1:0]     digit_count_ff, digit_count_in;
   logic [SIZE_W-1:0]   declared_size_ff, declared_size_in;
   logic [SIZE_W-1:0]   remaining_ff, remaining_in;
   logic [1:0]          bar_count_ff, bar_count_in;
   logic [FB_W-1:0]     field_bytes_ff, field_bytes_in;
   logic                lengths_match_ff, lengths_match_in;

   logic                out_valid_ff;
   logic [BYTE_W-1:0]   byte_out_ff, byte_out_in;
   logic [FCODE_W-1:0]  field_code_ff, field_code_in;
   logic                record_last_ff, record_last_in;
   logic                record_valid_ff, record_valid_in;
   logic [STATUS_W-1:0] status_ff, status_in;

   // Working values
   logic                accept;
   logic [BYTE_W-1:0]   in_byte;
   logic                first_of_file, end_of_file;
   logic [1:0]          cur_phase;
   logic [DC_W-1:0]     cur_digits;
   logic [SIZE_W-1:0]   cur_size, cur_remaining;
   logic [1:0]          cur_bars;
   logic [FB_W-1:0]     cur_fbytes;
   logic                cur_match;
   logic [SIZE_W-1:0]   prefix_len;
   logic [SIZE_W-1:0]   body_len;
   logic [SIZE_W-1:0]   size_times_ten;
   logic [SIZE_W-1:0]   remaining_dec;
   logic [LEN_W-1:0]    need_len;
   logic                is_digit;

   assign in_byte       = req_tdata[BYTE_W-1:0];
   assign first_of_file = req_tuser[0];
   assign end_of_file   = req_tuser[1];

   // Output register frees up when empty or being taken
   assign req_tready = !out_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // A first-of-file item sees a fresh parser
   always_comb begin
      if (first_of_file) begin
         cur_phase     = PH_SIZE;
         cur_digits    = '0;
         cur_size      = '0;
         cur_remaining = '0;
         cur_bars      = '0;
         cur_fbytes    = '0;
         cur_match     = 1'b1;
      end else begin
         cur_phase     = phase_ff;
         cur_digits    = digit_count_ff;
         cur_size      = declared_size_ff;
         cur_remaining = remaining_ff;
         cur_bars      = bar_count_ff;
         cur_fbytes    = field_bytes_ff;
         cur_match     = lengths_match_ff;
      end
   end

   // Arithmetic on the size and remaining count
   assign prefix_len     = SIZE_W'(cur_digits) + SIZE_W'(1);
   assign body_len       = cur_size - prefix_len;
   assign size_times_ten = (cur_size << 3) + (cur_size << 1)
                         + {{(SIZE_W-4){1'b0}}, in_byte[3:0]};
   assign remaining_dec  = cur_remaining - SIZE_W'(1);
   assign is_digit       = in_byte inside {[ZERO_CHAR:NINE_CHAR]};

   always_comb begin
      case (cur_bars)
         2'd0:    need_len = checksum_len_ff;
         2'd1:    need_len = timestamp_len_ff;
         default: need_len = type_len_ff;
      endcase
   end

   // Parser step
   always_comb begin
      phase_in         = cur_phase;
      digit_count_in   = cur_digits;
      declared_size_in = cur_size;
      remaining_in     = cur_remaining;
      bar_count_in     = cur_bars;
      field_bytes_in   = cur_fbytes;
      lengths_match_in = cur_match;
      byte_out_in      = '0;
      field_code_in    = FC_NONE;
      record_last_in   = 1'b0;
      record_valid_in  = 1'b0;
      status_in        = ST_OK;

      if (end_of_file) begin
         // Stream end: report, then start fresh unless halted
         if (cur_phase == PH_HALT) begin
            status_in = ST_HALTED;
         end else begin
            if (cur_phase == PH_BODY || cur_digits != '0) status_in = ST_TRUNCATED;
            phase_in         = PH_SIZE;
            digit_count_in   = '0;
            declared_size_in = '0;
            remaining_in     = '0;
            bar_count_in     = '0;
            field_bytes_in   = '0;
            lengths_match_in = 1'b1;
         end
      end else if (cur_phase == PH_HALT) begin
         status_in = ST_HALTED;
      end else if (cur_phase == PH_SIZE) begin
         // Size prefix digits and its bar
         if (in_byte == BAR_CHAR) begin
            if (cur_digits == '0) begin
               status_in = ST_EMPTY;
               phase_in  = PH_HALT;
            end else if (cur_size < prefix_len) begin
               status_in = ST_TOO_SMALL;
               phase_in  = PH_HALT;
            end else begin
               byte_out_in   = in_byte;
               field_code_in = FC_CONTENT;
               if (body_len == '0) begin
                  // Record is nothing but its prefix
                  record_last_in = 1'b1;
               end else begin
                  phase_in     = PH_BODY;
                  remaining_in = body_len;
               end
            end
            digit_count_in   = '0;
            declared_size_in = '0;
         end else if (!is_digit) begin
            status_in        = ST_BAD_DIGIT;
            phase_in         = PH_HALT;
            digit_count_in   = '0;
            declared_size_in = '0;
         end else if (cur_digits >= DC_W'(MAX_DIGITS)) begin
            status_in        = ST_TOO_MANY;
            phase_in         = PH_HALT;
            digit_count_in   = '0;
            declared_size_in = '0;
         end else begin
            digit_count_in   = cur_digits + DC_W'(1);
            declared_size_in = size_times_ten;
            byte_out_in      = in_byte;
            field_code_in    = FC_SIZE;
         end
      end else begin
         // Record body
         byte_out_in = in_byte;
         if (in_byte == BAR_CHAR && cur_bars != 2'd3) begin
            if (cur_fbytes != {1'b0, need_len}) lengths_match_in = 1'b0;
            bar_count_in   = cur_bars + 2'd1;
            field_bytes_in = '0;
            field_code_in  = FC_CONTENT;
         end else begin
            case (cur_bars)
               2'd0:    field_code_in = FC_CHECKSUM;
               2'd1:    field_code_in = FC_TIMESTAMP;
               2'd2:    field_code_in = FC_TYPE;
               default: field_code_in = FC_CONTENT;
            endcase
            if (cur_fbytes != FB_MAX) field_bytes_in = cur_fbytes + FB_W'(1);
         end
         remaining_in = remaining_dec;
         if (remaining_dec == '0) begin
            record_last_in   = 1'b1;
            record_valid_in  = (bar_count_in == 2'd3) && lengths_match_in;
            phase_in         = PH_SIZE;
            bar_count_in     = '0;
            field_bytes_in   = '0;
            lengths_match_in = 1'b1;
         end
      end
   end

   // Parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_SIZE;
         digit_count_ff   <= '0;
         declared_size_ff <= '0;
         remaining_ff     <= '0;
         bar_count_ff     <= '0;
         field_bytes_ff   <= '0;
         lengths_match_ff <= 1'b1;
      end else if (accept) begin
         phase_ff         <= phase_in;
         digit_count_ff   <= digit_count_in;
         declared_size_ff <= declared_size_in;
         remaining_ff     <= remaining_in;
         bar_count_ff     <= bar_count_in;
         field_bytes_ff   <= field_bytes_in;
         lengths_match_ff <= lengths_match_in;
      end
   end

   // Output register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (accept) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   // Output register payload
   always_ff @(posedge clock) begin
      if (accept) begin
         byte_out_ff     <= byte_out_in;
         field_code_ff   <= field_code_in;
         record_last_ff  <= record_last_in;
         record_valid_ff <= record_valid_in;
         status_ff       <= status_in;
      end
   end

   // Field length registers
   always_ff @(posedge clock) begin
      if (reset) begin
         checksum_len_ff  <= CHECKSUM_LEN_RST;
         timestamp_len_ff <= TIMESTAMP_LEN_RST;
         type_len_ff      <= TYPE_LEN_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CHECKSUM_LEN:  checksum_len_ff  <= csr_wdata;
            CSR_TIMESTAMP_LEN: timestamp_len_ff <= csr_wdata;
            CSR_TYPE_LEN:      type_len_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0, status_ff, record_valid_ff, byte_out_ff};
   assign rsp_tuser  = field_code_ff;
   assign rsp_tlast  = record_last_ff;

`ifndef ASSERT_OFF
   // A valid verdict only comes with the record's last byte
   a_valid_needs_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[8]) |-> rsp_tlast)
      else $error("record_valid without record_last");

   // A byte that is not taken is reported as zero
   a_none_zero_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == FC_NONE) |-> (rsp_tdata[7:0] == '0))
      else $error("byte passed on a result with no field");

   // Body bars are only counted inside a record body
   a_bars_in_body: assert property (@(posedge clock) disable iff (reset)
      (bar_count_ff != 2'd0) |-> (phase_ff == PH_BODY))
      else $error("bar count outside record body");

   // Size digits are only held while reading the size
   a_digits_in_size: assert property (@(posedge clock) disable iff (reset)
      (digit_count_ff != '0) |-> (phase_ff == PH_SIZE))
      else $error("digit count outside size phase");
`endif

endmodule

[tb/tb_size_prefixed_record_deframer_unit.sv]
// Self-checking testbench for the size-prefixed record deframer unit.
`timescale 1ns / 1ps

module tb_size_prefixed_record_deframer_unit
   import sprd_pkg::*;
();

   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int ITEMS_PER_PHASE = 90;
   localparam int HOLD_CYCLES     = 300;
   localparam int NUM_PHASES      = 6;
   // Index past the end of the register map; writes to it must be ignored
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   // One tagged byte as the block reports it
   typedef struct packed {
      logic [BYTE_W-1:0]   byte_out;
      logic [FCODE_W-1:0]  field_code;
      logic                record_last;
      logic                record_valid;
      logic [STATUS_W-1:0] status;
   } tag_type;

   // Directed stimulus row, with an optional typed-in expectation
   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              first;
      logic              eof;
      logic              typed;
      tag_type           tag;
   } row_type;

   typedef enum {
      REC_GOOD, REC_NO_BAR, REC_SIZE_OFF, REC_TRUNC, REC_BAD_DIGIT,
      REC_TOO_MANY, REC_EMPTY, REC_LONG, REC_PADDED
   } rec_kind_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [REQ_TUSER_W-1:0] req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [LEN_W-1:0]       csr_wdata = '0;

   size_prefixed_record_deframer_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Predictor copy of the parser state and the length registers
   logic [1:0]        ps_phase;
   logic [3:0]        ps_digits;
   logic [SIZE_W-1:0] ps_size;
   logic [SIZE_W-1:0] ps_left;
   logic [1:0]        ps_bars;
   logic [FB_W-1:0]   ps_fbytes;
   logic              ps_lens_ok;
   logic [LEN_W-1:0]  len_chk;
   logic [LEN_W-1:0]  len_ts;
   logic [LEN_W-1:0]  len_typ;

   tag_type expected_tags[$];
   row_type dir_rows[$];
   logic [BYTE_W-1:0] body_q[$];
   logic [BYTE_W-1:0] frame_q[$];

   // Driver and receiver controls
   logic    row_typed = 1'b0;
   tag_type row_tag = '0;
   int      send_pct = 0;
   int      recv_pct = 0;
   int      hold_req = 0;
   int      hold_left = 0;
   int      phase_stop = 0;

   // Tallies
   int errors = 0;
   int n_sent = 0;
   int live_items = 0;
   int n_records = 0;
   int n_valid = 0;
   int n_prefix_err = 0;
   int n_trunc = 0;
   int stall_cycles = 0;

   function automatic tag_type mk_tag(input logic [BYTE_W-1:0] b,
                                      input logic [FCODE_W-1:0] fc,
                                      input logic last, input logic valid,
                                      input logic [STATUS_W-1:0] st);
      tag_type t;
      t.byte_out     = b;
      t.field_code   = fc;
      t.record_last  = last;
      t.record_valid = valid;
      t.status       = st;
      return t;
   endfunction

   function automatic void restart_parse();
      ps_phase   = PH_SIZE;
      ps_digits  = '0;
      ps_size    = '0;
      ps_left    = '0;
      ps_bars    = '0;
      ps_fbytes  = '0;
      ps_lens_ok = 1'b1;
   endfunction

   // Malformed prefix: byte dropped, stream halted until the next file
   function automatic tag_type halt_parse(input logic [STATUS_W-1:0] st);
      restart_parse();
      ps_phase = PH_HALT;
      return mk_tag('0, FC_NONE, 1'b0, 1'b0, st);
   endfunction

   // Advance the predicted parser by one item and return the expected tag
   function automatic tag_type deframe(input logic [BYTE_W-1:0] b, input logic first,
                                       input logic eof);
      tag_type            t;
      logic [SIZE_W-1:0]  prefix;
      logic [LEN_W-1:0]   need;
      logic [FCODE_W-1:0] fc;
      t = mk_tag('0, FC_NONE, 1'b0, 1'b0, ST_OK);
      if (first) restart_parse();
      if (eof) begin
         if (ps_phase == PH_HALT) begin
            t.status = ST_HALTED;
         end else begin
            if (ps_phase == PH_BODY || ps_digits != 0) t.status = ST_TRUNCATED;
            restart_parse();
         end
      end else if (ps_phase == PH_HALT) begin
         t.status = ST_HALTED;
      end else if (ps_phase == PH_SIZE) begin
         if (b == BAR_CHAR) begin
            prefix = SIZE_W'(ps_digits) + SIZE_W'(1);
            if (ps_digits == 0) begin
               t = halt_parse(ST_EMPTY);
            end else if (ps_size < prefix) begin
               t = halt_parse(ST_TOO_SMALL);
            end else begin
               ps_left = ps_size - prefix;
               if (ps_left == 0) begin
                  // record is nothing but its prefix
                  restart_parse();
                  t = mk_tag(b, FC_CONTENT, 1'b1, 1'b0, ST_OK);
               end else begin
                  ps_phase   = PH_BODY;
                  ps_bars    = '0;
                  ps_fbytes  = '0;
                  ps_lens_ok = 1'b1;
                  t = mk_tag(b, FC_CONTENT, 1'b0, 1'b0, ST_OK);
               end
            end
         end else if (b < ZERO_CHAR || b > NINE_CHAR) begin
            t = halt_parse(ST_BAD_DIGIT);
         end else if (ps_digits >= 4'(MAX_DIGITS_DEFAULT)) begin
            t = halt_parse(ST_TOO_MANY);
         end else begin
            ps_digits = ps_digits + 4'd1;
            ps_size   = ps_size * SIZE_W'(10) + SIZE_W'(b - ZERO_CHAR);
            t = mk_tag(b, FC_SIZE, 1'b0, 1'b0, ST_OK);
         end
      end else begin
         // body: the first three bars close the fixed fields
         if (b == BAR_CHAR && ps_bars < 2'd3) begin
            case (ps_bars)
               2'd0:    need = len_chk;
               2'd1:    need = len_ts;
               default: need = len_typ;
            endcase
            if (ps_fbytes != {1'b0, need}) ps_lens_ok = 1'b0;
            ps_bars   = ps_bars + 2'd1;
            ps_fbytes = '0;
            fc = FC_CONTENT;
         end else begin
            fc = (ps_bars == 2'd3) ? FC_CONTENT : FC_CHECKSUM + FCODE_W'(ps_bars);
            if (ps_fbytes < FB_MAX) ps_fbytes = ps_fbytes + FB_W'(1);
         end
         ps_left = ps_left - SIZE_W'(1);
         if (ps_left == 0) begin
            t = mk_tag(b, fc, 1'b1, (ps_bars == 2'd3) && ps_lens_ok, ST_OK);
            restart_parse();
         end else begin
            t = mk_tag(b, fc, 1'b0, 1'b0, ST_OK);
         end
      end
      return t;
   endfunction

   // Scoreboard: predict on input handshake, compare on output handshake
   always @(posedge clock) begin : scoreboard
      tag_type want;
      tag_type got;
      if (reset) begin
         restart_parse();
         len_chk = CHECKSUM_LEN_RST;
         len_ts  = TIMESTAMP_LEN_RST;
         len_typ = TYPE_LEN_RST;
         stall_cycles = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_CHECKSUM_LEN:  len_chk = csr_wdata;
               CSR_TIMESTAMP_LEN: len_ts  = csr_wdata;
               CSR_TYPE_LEN:      len_typ = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            want = deframe(req_tdata, req_tuser[0], req_tuser[1]);
            if (want.status != ST_HALTED) live_items++;
            if (want.record_last) n_records++;
            if (want.record_valid) n_valid++;
            if (want.status inside {ST_BAD_DIGIT, ST_TOO_MANY, ST_EMPTY, ST_TOO_SMALL})
               n_prefix_err++;
            if (want.status == ST_TRUNCATED) n_trunc++;
            expected_tags = {expected_tags, (row_typed ? row_tag : want)};
         end
         if (rsp_tvalid && rsp_tready) begin
            got = mk_tag(rsp_tdata[7:0], rsp_tuser, rsp_tlast, rsp_tdata[8],
                         rsp_tdata[11:9]);
            if (expected_tags.size() == 0) begin
               errors++;
               $display("%0t: result with nothing expected", $time);
               $display("%0t:   actual byte %h field %0d last %b valid %b status %0d",
                        $time, got.byte_out, got.field_code, got.record_last,
                        got.record_valid, got.status);
            end else begin
               want = expected_tags.pop_front();
               if (got.byte_out !== want.byte_out || got.field_code !== want.field_code ||
                   got.record_last !== want.record_last ||
                   got.record_valid !== want.record_valid || got.status !== want.status) begin
                  errors++;
                  $display("%0t: expected byte %h field %0d last %b valid %b status %0d",
                           $time, want.byte_out, want.field_code, want.record_last,
                           want.record_valid, want.status);
                  $display("%0t:   actual byte %h field %0d last %b valid %b status %0d",
                           $time, got.byte_out, got.field_code, got.record_last,
                           got.record_valid, got.status);
               end
            end
         end
         // watchdog on handshake activity
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("size_prefixed_record_deframer_unit: mismatch");
            $finish;
         end
      end
   end

   // Result side: random back-pressure, or a long hold-off when asked
   always @(negedge clock) begin : receiver
      if (hold_req != 0) begin
         hold_left = hold_req;
         hold_req  = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready = 1'b0;
      end else begin
         rsp_tready = ($urandom_range(99) >= recv_pct);
      end
   end

   // Offer one item and wait for it to be taken; called at a falling edge
   task automatic send(input logic [BYTE_W-1:0] b, input logic first, input logic eof,
                       input logic typed, input tag_type tag);
      while ($urandom_range(99) < send_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tdata  = b;
      req_tuser  = {eof, first};
      row_typed  = typed;
      row_tag    = tag;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      n_sent++;
      @(negedge clock);
   endtask

   // Stop offering and wait for every outstanding result
   task automatic settle();
      req_tvalid = 1'b0;
      while (expected_tags.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [LEN_W-1:0] val);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic set_lengths(input int chk, input int ts, input int typ);
      write_csr(CSR_CHECKSUM_LEN, LEN_W'(chk));
      write_csr(CSR_TIMESTAMP_LEN, LEN_W'(ts));
      write_csr(CSR_TYPE_LEN, LEN_W'(typ));
   endtask

   task automatic add_row(input logic [BYTE_W-1:0] b, input logic first, input logic eof,
                          input logic typed, input tag_type tag);
      row_type r;
      r.data  = b;
      r.first = first;
      r.eof   = eof;
      r.typed = typed;
      r.tag   = tag;
      dir_rows = {dir_rows, r};
   endtask

   function automatic int num_digits(input int v);
      int n;
      n = 1;
      while (v >= 10) begin
         v = v / 10;
         n++;
      end
      return n;
   endfunction

   function automatic logic [BYTE_W-1:0] plain_byte();
      logic [BYTE_W-1:0] c;
      do c = BYTE_W'($urandom_range(255)); while (c == BAR_CHAR);
      return c;
   endfunction

   // Assemble one record of the given kind into frame_q
   task automatic build_record(input rec_kind_type kind);
      int fl[3];
      int cont_n;
      int skip_bar;
      int z;
      int d;
      int decl;
      int v;
      logic [BYTE_W-1:0] c;
      body_q.delete();
      frame_q.delete();
      fl[0] = int'(len_chk);
      fl[1] = int'(len_ts);
      fl[2] = int'(len_typ);
      for (int i = 0; i < 3; i++)
         if ($urandom_range(4) == 0) fl[i] = int'($urandom_range(6));
      if (kind == REC_LONG) fl[0] = 128 + int'($urandom_range(12));
      skip_bar = (kind == REC_NO_BAR) ? int'($urandom_range(2)) : -1;
      cont_n = int'($urandom_range(6));
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < fl[i]; j++) body_q = {body_q, plain_byte()};
         if (i != skip_bar) body_q = {body_q, BAR_CHAR};
      end
      for (int j = 0; j < cont_n; j++)
         body_q = {body_q, (($urandom_range(7) == 0) ? BAR_CHAR
                                                     : BYTE_W'($urandom_range(255)))};
      // size counts its own digits, leading zeros and bar
      z = (kind == REC_PADDED) ? int'($urandom_range(1, 3)) : 0;
      d = 1;
      while (num_digits(body_q.size() + 1 + z + d) != d) d++;
      decl = body_q.size() + 1 + z + d;
      if (kind == REC_SIZE_OFF) begin
         if ($urandom_range(1) == 0) decl = decl + int'($urandom_range(1, 3));
         else decl = decl - int'($urandom_range(1, 3));
         if (decl < 0) decl = 0;
      end
      if (kind == REC_TOO_MANY) z = MAX_DIGITS_DEFAULT + 1 - num_digits(decl);
      v = decl;
      do begin
         frame_q.push_front(ZERO_CHAR + BYTE_W'(v % 10));
         v = v / 10;
      end while (v != 0);
      repeat (z) frame_q.push_front(ZERO_CHAR);
      if (kind == REC_BAD_DIGIT) begin
         do c = BYTE_W'($urandom_range(255));
         while ((c >= ZERO_CHAR && c <= NINE_CHAR) || c == BAR_CHAR);
         frame_q[$urandom_range(frame_q.size() - 1)] = c;
      end
      if (kind == REC_EMPTY) frame_q.delete();
      frame_q = {frame_q, BAR_CHAR};
      foreach (body_q[i]) frame_q = {frame_q, body_q[i]};
   endtask

   // One file: a few records, mostly well formed, usually closed by end of file
   task automatic send_file();
      int n;
      int r;
      int cut;
      logic head;
      rec_kind_type kind;
      head = 1'b1;
      kind = REC_GOOD;
      n = int'($urandom_range(1, 3));
      for (int k = 0; k < n && kind != REC_TRUNC && n_sent < phase_stop; k++) begin
         r = int'($urandom_range(99));
         if (r < 62)      kind = REC_GOOD;
         else if (r < 69) kind = REC_NO_BAR;
         else if (r < 75) kind = REC_SIZE_OFF;
         else if (r < 81) kind = REC_TRUNC;
         else if (r < 85) kind = REC_BAD_DIGIT;
         else if (r < 88) kind = REC_TOO_MANY;
         else if (r < 91) kind = REC_EMPTY;
         else if (r < 94) kind = REC_LONG;
         else             kind = REC_PADDED;
         build_record(kind);
         cut = (kind == REC_TRUNC) ? int'($urandom_range(1, frame_q.size() - 1))
                                   : frame_q.size();
         for (int i = 0; i < cut; i++) begin
            send(frame_q[i], head, 1'b0, 1'b0, '0);
            head = 1'b0;
         end
      end
      if (kind == REC_TRUNC || $urandom_range(99) < 85)
         send(BYTE_W'($urandom_range(255)), $urandom_range(9) == 0, 1'b1, 1'b0, '0);
   endtask

   // Stray bytes with random file markers
   task automatic send_noise();
      repeat ($urandom_range(1, 4))
         send(BYTE_W'($urandom_range(255)), $urandom_range(7) == 0,
              $urandom_range(7) == 0, 1'b0, '0);
   endtask

   task automatic random_traffic(input bit pressure);
      int saved_pct;
      bit held;
      bit paused;
      held       = 1'b0;
      paused     = 1'b0;
      phase_stop = n_sent + ITEMS_PER_PHASE;
      while (n_sent < phase_stop) begin
         if (pressure && !held) begin
            // receiver holds off while the sender keeps offering at full rate
            held      = 1'b1;
            hold_req  = HOLD_CYCLES;
            saved_pct = send_pct;
            send_pct  = 0;
            send_file();
            send_pct  = saved_pct;
         end else if (pressure && !paused && phase_stop - n_sent < 45) begin
            paused = 1'b1;
            settle();
         end else if ($urandom_range(99) < 85) begin
            send_file();
         end else begin
            send_noise();
         end
      end
   endtask

   initial begin : stimulus
      row_type r;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part, with short field lengths so whole records fit
      set_lengths(1, 0, 1);
      add_row(8'h00, 1'b0, 1'b1, 1'b1, mk_tag(8'h00, FC_NONE, 1'b0, 1'b0, ST_OK));
      add_row(BAR_CHAR, 1'b0, 1'b0, 1'b1, mk_tag(8'h00, FC_NONE, 1'b0, 1'b0, ST_EMPTY));
      add_row(8'hFF, 1'b0, 1'b0, 1'b1, mk_tag(8'h00, FC_NONE, 1'b0, 1'b0, ST_HALTED));
      add_row(8'h41, 1'b0, 1'b1, 1'b1, mk_tag(8'h00, FC_NONE, 1'b0, 1'b0, ST_HALTED));
      // size equal to its own prefix
      add_row(ZERO_CHAR + 8'd2, 1'b1, 1'b0, 1'b1,
              mk_tag(ZERO_CHAR + 8'd2, FC_SIZE, 1'b0, 1'b0, ST_OK));
      add_row(BAR_CHAR, 1'b0, 1'b0, 1'b1, mk_tag(BAR_CHAR, FC_CONTENT, 1'b1, 1'b0, ST_OK));
      // minimal valid record with extreme byte values
      add_row(ZERO_CHAR + 8'd7, 1'b0, 1'b0, 1'b1,
              mk_tag(ZERO_CHAR + 8'd7, FC_SIZE, 1'b0, 1'b0, ST_OK));
      add_row(BAR_CHAR, 1'b0, 1'b0, 1'b1, mk_tag(BAR_CHAR, FC_CONTENT, 1'b0, 1'b0, ST_OK));
      add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
      add_row(BAR_CHAR, 1'b0, 1'b0, 1'b0, '0);
      add_row(BAR_CHAR, 1'b0, 1'b0, 1'b0, '0);
      add_row(8'hFF, 1'b0, 1'b0, 1'b0, '0);
      add_row(BAR_CHAR, 1'b0, 1'b0, 1'b0, '0);
      // bar in content after the third body bar
      add_row(ZERO_CHAR + 8'd8, 1'b0, 1'b0, 1'b0, '0);
      add_row(BAR_CHAR, 1'b0, 1'b0, 1'b0, '0);
      add_row(8'h61, 1'b0, 1'b0, 1'b0, '0);
      add_row(BAR_CHAR, 1'b0, 1'b0, 1'b0, '0);
      add_row(BAR_CHAR, 1'b0, 1'b0, 1'b0, '0);
      add_row(8'h78, 1'b0, 1'b0, 1'b0, '0);
      add_row(BAR_CHAR, 1'b0, 1'b0, 1'b0, '0);
      add_row(BAR_CHAR, 1'b0, 1'b0, 1'b0, '0);
      // prefix errors, restart, clean and truncated ends
      add_row(8'h3A, 1'b1, 1'b0, 1'b1, mk_tag(8'h00, FC_NONE, 1'b0, 1'b0, ST_BAD_DIGIT));
      add_row(ZERO_CHAR, 1'b1, 1'b0, 1'b1, mk_tag(ZERO_CHAR, FC_SIZE, 1'b0, 1'b0, ST_OK));
      add_row(BAR_CHAR, 1'b0, 1'b0, 1'b1, mk_tag(8'h00, FC_NONE, 1'b0, 1'b0, ST_TOO_SMALL));
      add_row(8'hFF, 1'b1, 1'b1, 1'b1, mk_tag(8'h00, FC_NONE, 1'b0, 1'b0, ST_OK));
      add_row(NINE_CHAR, 1'b0, 1'b0, 1'b1, mk_tag(NINE_CHAR, FC_SIZE, 1'b0, 1'b0, ST_OK));
      add_row(8'h00, 1'b0, 1'b1, 1'b1, mk_tag(8'h00, FC_NONE, 1'b0, 1'b0, ST_TRUNCATED));
      send_pct = 24;
      recv_pct = 61;
      foreach (dir_rows[i]) begin
         r = dir_rows[i];
         send(r.data, r.first, r.eof, r.typed, r.tag);
      end

      // Random part: idle mode changes every two phases, lengths every phase
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         settle();
         if (ph < 2) begin
            send_pct = 24;
            recv_pct = 61;
         end else if (ph < 4) begin
            send_pct = 61;
            recv_pct = 24;
         end else begin
            send_pct = 0;
            recv_pct = 0;
         end
         case (ph)
            0: set_lengths(CHECKSUM_LEN_RST, TIMESTAMP_LEN_RST, TYPE_LEN_RST);
            1: begin
               set_lengths(0, 0, 0);
               write_csr(CSR_UNUSED, 6'h3F);
            end
            2: set_lengths(63, 0, 0);
            4: set_lengths(2, 5, 1);
            default: set_lengths(int'($urandom_range(20)), int'($urandom_range(20)),
                                 int'($urandom_range(20)));
         endcase
         random_traffic(ph == 0);
      end

      settle();
      $display("Covered %0d parsed items in %0d records (%0d valid) over six length settings,",
               live_items, n_records, n_valid);
      $display("with %0d prefix errors, %0d truncated files and %0d failures.",
               n_prefix_err, n_trunc, errors);
      if (errors == 0) begin
         $display("size_prefixed_record_deframer_unit: match");
      end else begin
         $display("size_prefixed_record_deframer_unit: mismatch");
      end
      $finish;
   end

endmodule
